[src/bdlp_pkg.sv]
// Package for the debounced button with long-press detection.
// Holds the item, result and configuration types, the state and event codes and
// the register indexes. It has no dependencies.
package bdlp_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned EVENT_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

    // Button qualifier states
    localparam logic [STATE_W-1:0] ST_INACTIVE       = 3'd0;
    localparam logic [STATE_W-1:0] ST_PRESS_BOUNCE   = 3'd1;
    localparam logic [STATE_W-1:0] ST_ACTIVE         = 3'd2;
    localparam logic [STATE_W-1:0] ST_LONG_HELD      = 3'd3;
    localparam logic [STATE_W-1:0] ST_RELEASE_BOUNCE = 3'd4;

    // Latched event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PRESSED  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 2'd2;
    localparam logic [EVENT_W-1:0] EV_LONG     = 2'd3;

    // Item operations
    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL  = 2'd2;

    // Register reset values
    localparam logic [MS_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [MS_W-1:0] LONG_PRESS_MS_RST = 16'd1500;
    localparam logic            ACTIVE_LEVEL_RST  = 1'b0;

    typedef struct packed {
        logic               op;
        logic               pin_level;
        logic [TIME_W-1:0]  now_ms;
        logic [EVENT_W-1:0] asked_event;
    } t_item;

    typedef struct packed {
        logic               check_hit;
        logic [EVENT_W-1:0] latched_event;
        logic [STATE_W-1:0] button_state;
    } t_result;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic            active_level;
    } t_cfg;

endpackage

[src/bdlp_cfg.sv]
// Configuration registers: debounce time, long-press time and active pin level.
// Depends on bdlp_pkg.
module bdlp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]   i_data,
    output bdlp_pkg::t_cfg                    o_cfg
);

    bdlp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bdlp_pkg::DEBOUNCE_MS_RST;
            r_cfg.long_press_ms <= bdlp_pkg::LONG_PRESS_MS_RST;
            r_cfg.active_level  <= bdlp_pkg::ACTIVE_LEVEL_RST;
        end else if (i_we) begin
            unique case (i_idx)
                bdlp_pkg::CFG_DEBOUNCE_MS:   r_cfg.debounce_ms   <= i_data;
                bdlp_pkg::CFG_LONG_PRESS_MS: r_cfg.long_press_ms <= i_data;
                bdlp_pkg::CFG_ACTIVE_LEVEL:  r_cfg.active_level  <= i_data[0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/bdlp_in_stage.sv]
// Input register stage: holds one accepted transaction for the state logic.
// Depends on bdlp_pkg.
module bdlp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bdlp_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output bdlp_pkg::t_item o_item
);

    logic            r_valid;
    bdlp_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/bdlp_core.sv]
// Button state machine, time mark and event latch; one item per cycle while i_fire is high.
// Depends on bdlp_pkg.
module bdlp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bdlp_pkg::t_item   i_item,
    input  bdlp_pkg::t_cfg    i_cfg,
    output bdlp_pkg::t_result o_result
);

    logic [bdlp_pkg::STATE_W-1:0] r_state, n_state;
    logic [bdlp_pkg::TIME_W-1:0]  r_mark,  n_mark;
    logic [bdlp_pkg::EVENT_W-1:0] r_event, n_event;
    logic [bdlp_pkg::TIME_W-1:0]  elapsed;
    logic                         pressed;
    logic                         deb_done;
    logic                         long_done;
    logic                         hit;

    assign pressed = (i_item.pin_level == i_cfg.active_level);
    assign elapsed = i_item.now_ms - r_mark;  // wraps mod 2^32

    // elapsed > 16-bit limit: any high bit set, or low half above the limit
    assign deb_done  = (|elapsed[bdlp_pkg::TIME_W-1:bdlp_pkg::MS_W]) ||
                       (elapsed[bdlp_pkg::MS_W-1:0] > i_cfg.debounce_ms);
    assign long_done = (|elapsed[bdlp_pkg::TIME_W-1:bdlp_pkg::MS_W]) ||
                       (elapsed[bdlp_pkg::MS_W-1:0] > i_cfg.long_press_ms);

    always_comb begin
        n_state = r_state;
        n_mark  = r_mark;
        n_event = r_event;
        hit     = 1'b0;
        if (i_item.op == bdlp_pkg::OP_POLL) begin
            unique case (r_state)
                bdlp_pkg::ST_INACTIVE: begin
                    if (pressed) begin
                        n_mark  = i_item.now_ms;
                        n_state = bdlp_pkg::ST_PRESS_BOUNCE;
                        n_event = bdlp_pkg::EV_PRESSED;
                    end
                end
                bdlp_pkg::ST_PRESS_BOUNCE: begin
                    if (deb_done) begin
                        n_mark  = i_item.now_ms;
                        n_state = bdlp_pkg::ST_ACTIVE;
                    end
                end
                bdlp_pkg::ST_ACTIVE: begin
                    // release wins over long press
                    if (!pressed) begin
                        n_mark  = i_item.now_ms;
                        n_state = bdlp_pkg::ST_RELEASE_BOUNCE;
                        n_event = bdlp_pkg::EV_RELEASED;
                    end else if (long_done) begin
                        n_state = bdlp_pkg::ST_LONG_HELD;
                        n_event = bdlp_pkg::EV_LONG;
                    end
                end
                bdlp_pkg::ST_LONG_HELD: begin
                    if (!pressed) begin
                        n_mark  = i_item.now_ms;
                        n_state = bdlp_pkg::ST_RELEASE_BOUNCE;
                    end
                end
                bdlp_pkg::ST_RELEASE_BOUNCE: begin
                    if (deb_done) begin
                        n_state = bdlp_pkg::ST_INACTIVE;
                    end
                end
                default: n_state = bdlp_pkg::ST_INACTIVE;
            endcase
        end else if (r_event == i_item.asked_event) begin
            n_event = bdlp_pkg::EV_NONE;
            hit     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdlp_pkg::ST_INACTIVE;
            r_mark  <= '0;
            r_event <= bdlp_pkg::EV_NONE;
        end else if (i_fire) begin
            r_state <= n_state;
            r_mark  <= n_mark;
            r_event <= n_event;
        end
    end

    assign o_result.check_hit     = hit;
    assign o_result.latched_event = n_event;
    assign o_result.button_state  = n_state;

endmodule

[src/bdlp_out_stage.sv]
// Output result register; takes a new result whenever empty or being drained.
// Depends on bdlp_pkg.
module bdlp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bdlp_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output bdlp_pkg::t_result o_result
);

    logic              r_valid;
    bdlp_pkg::t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[src/button_debounce_long_press.sv]
// Top level of the debounced button with long-press detection.
// Depends on bdlp_pkg, bdlp_cfg, bdlp_in_stage, bdlp_core and bdlp_out_stage.
//
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | poll or check transaction, tuser = op
//  m_axis    | out       | one result per input transaction
//  i_cfg_*   | in        | register write: 0 debounce, 1 long press, 2 level
//
// A transaction passes through the input register and then the result register;
// one transaction is taken per cycle while m_axis does not stall. The state update
// (wrapping time difference and compare) sits between the two registers.
// Reset is synchronous, active low; it empties both stages and loads defaults.
// A stall on m_axis backs up into s_axis once both registers are full.
module button_debounce_long_press (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pin_level[0], now_ms[32:1], asked_event[34:33], zero fill [39:35]
    input  logic [bdlp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: op (0 poll, 1 check and clear)
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: check_hit[0], latched_event[2:1], button_state[5:3], zero [7:6]
    output logic [bdlp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bdlp_pkg::t_item   in_item;
    bdlp_pkg::t_item   stage_item;
    bdlp_pkg::t_result core_result;
    bdlp_pkg::t_result out_result;
    bdlp_pkg::t_cfg    cfg;
    logic              stage_valid;
    logic              out_ready;
    logic              fire;

    assign in_item.op          = s_axis_tuser;
    assign in_item.pin_level   = s_axis_tdata[0];
    assign in_item.now_ms      = s_axis_tdata[32:1];
    assign in_item.asked_event = s_axis_tdata[34:33];

    assign fire = stage_valid && out_ready;

    bdlp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bdlp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_ready (out_ready),
        .o_item  (stage_item)
    );

    bdlp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    bdlp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {2'b00, out_result.button_state,
                           out_result.latched_event, out_result.check_hit};

endmodule
